/* hw/rtl/tkst_pkg.sv */
`timescale 1ns / 1ps

package tkst_pkg;

    // Fixed field widths
    localparam int SCORE_W = 31;
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;

    // Operation codes on s_func
    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_READ   = 1'b1
    } func_t;

    // What a cell hands to its right-hand neighbor
    typedef struct packed {
        logic               take;   // new score belongs at or before this cell
        logic               valid;  // cell holds an entry
        logic [SCORE_W-1:0] score;  // held score
    } tkst_link_t;

endpackage

/* hw/rtl/tkst_cell.sv */
`timescale 1ns / 1ps

module tkst_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ins_en,
    input  logic [tkst_pkg::SCORE_W-1:0]  new_score,
    input  tkst_pkg::tkst_link_t          prev_link,
    output tkst_pkg::tkst_link_t          link
);
    import tkst_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [SCORE_W-1:0] score_reg;
    logic [SCORE_W-1:0] score_next;
    logic               take;

    // Empty cell or strictly smaller entry: new score goes here or earlier
    assign take = !valid_reg || (new_score > score_reg);

    assign link.take  = take;
    assign link.valid = valid_reg;
    assign link.score = score_reg;

    // Shift from left neighbor, or write the new score at the insert point
    always_comb begin
        valid_next = valid_reg;
        score_next = score_reg;
        if (ins_en && take) begin
            if (prev_link.take) begin
                valid_next = prev_link.valid;
                score_next = prev_link.score;
            end else begin
                valid_next = 1'b1;
                score_next = new_score;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Score payload, no reset needed
    always_ff @(posedge aclk) begin
        score_reg <= score_next;
    end

endmodule

/* hw/rtl/top_k_sorted_insert_table.sv */
`timescale 1ns / 1ps

// Top-k sorted score table.
// Input beats (s_valid/s_ready) carry an operation: s_func insert puts
// s_new_score into a descending table of DEPTH entries (after equal scores);
// s_func read returns the entry at s_read_index. Every input beat yields
// exactly one result beat (m_valid/m_ready) holding placed/position for an
// insert, entry_score/entry_valid for a read, and the fill count after the
// operation. A full table drops its last entry when a better score arrives;
// a score that beats nothing in a full table is rejected (position = DEPTH).
// The table is a row of DEPTH cells: each compares its own entry against the
// new score and takes either the new score or its left neighbor's entry in
// the same cycle. The result beat is registered and appears in the cycle after
// the input beat; one item is taken per cycle while the result register drains.
// A single output register parts the channels: a new beat is taken while the
// result register is empty or being drained; while m_ready is low with a
// result pending, s_ready is low and the result holds.
// Synchronous active-low reset empties all cells and clears the count; the
// block is ready as soon as reset is released.

module top_k_sorted_insert_table #(
    parameter int DEPTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [tkst_pkg::SCORE_W-1:0]  s_new_score,
    input  logic [tkst_pkg::IDX_W-1:0]    s_read_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_placed,
    output logic [tkst_pkg::CNT_W-1:0]    m_position,
    output logic [tkst_pkg::SCORE_W-1:0]  m_entry_score,
    output logic                          m_entry_valid,
    output logic [tkst_pkg::CNT_W-1:0]    m_fill_count
);
    import tkst_pkg::*;

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic                s_beat;
    logic                ins_en;
    tkst_link_t          links   [DEPTH];
    tkst_link_t          prevs   [DEPTH];
    logic [DEPTH-1:0]    valid_vec;

    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                placed;
    logic [CNT_W-1:0]    ins_pos;
    logic [SCORE_W-1:0]  rd_score;
    logic                rd_valid;

    logic                m_valid_reg,  m_valid_next;
    logic                placed_reg,   placed_next;
    logic [CNT_W-1:0]    position_reg, position_next;
    logic [SCORE_W-1:0]  escore_reg,   escore_next;
    logic                evalid_reg,   evalid_next;
    logic [CNT_W-1:0]    fill_reg,     fill_next;

    // Handshake: take a beat when the result register is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign s_beat  = s_valid && s_ready;
    assign ins_en  = s_beat && (func_t'(s_func) == FUNC_INSERT);

    // Cell row
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign prevs[i] = '0;
        end else begin : g_body
            assign prevs[i] = links[i-1];
        end

        tkst_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ins_en    (ins_en),
            .new_score (s_new_score),
            .prev_link (prevs[i]),
            .link      (links[i])
        );

        assign valid_vec[i] = links[i].valid;
    end

    // Take flags form a thermometer; the last cell's flag says it fits
    assign placed = links[DEPTH-1].take;

    // Insert point: the one cell whose flag rises, OR-reduced to an index
    always_comb begin
        ins_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (links[i].take && !prevs[i].take) begin
                ins_pos = ins_pos | CNT_W'(i);
            end
        end
        if (!placed) begin
            ins_pos = CNT_W'(DEPTH);
        end
    end

    // Read select: one-hot match per cell, OR-reduced
    always_comb begin
        rd_score = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if ({1'b0, s_read_index} == CNT_W'(i)) begin
                rd_score = rd_score | links[i].score;
            end
        end
    end

    assign rd_valid = {1'b0, s_read_index} < CNT_W'(count_reg);

    // Fill count
    always_comb begin
        count_next = count_reg;
        if (ins_en && placed && (count_reg != CNT_BITS'(DEPTH))) begin
            count_next = count_reg + CNT_BITS'(1);
        end
    end

    // Result register
    always_comb begin
        m_valid_next  = m_valid_reg;
        placed_next   = placed_reg;
        position_next = position_reg;
        escore_next   = escore_reg;
        evalid_next   = evalid_reg;
        fill_next     = fill_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_beat) begin
            m_valid_next = 1'b1;
            fill_next    = CNT_W'(count_next);
            if (func_t'(s_func) == FUNC_INSERT) begin
                placed_next   = placed;
                position_next = ins_pos;
                escore_next   = '0;
                evalid_next   = 1'b0;
            end else begin
                placed_next   = 1'b0;
                position_next = '0;
                escore_next   = rd_valid ? rd_score : '0;
                evalid_next   = rd_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
        end else begin
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        placed_reg   <= placed_next;
        position_reg <= position_next;
        escore_reg   <= escore_next;
        evalid_reg   <= evalid_next;
        fill_reg     <= fill_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_placed      = placed_reg;
    assign m_position    = position_reg;
    assign m_entry_score = escore_reg;
    assign m_entry_valid = evalid_reg;
    assign m_fill_count  = fill_reg;

`ifndef SYNTHESIS
    // Occupied cells always match the fill count
    a_count_matches: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("cell occupancy differs from fill count");

    // Count never exceeds the table size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_BITS'(DEPTH))
        else $error("fill count above DEPTH");

    // A placed score lands inside the table
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_placed |-> m_position < CNT_W'(DEPTH))
        else $error("placed position out of range");

    // A rejected insert leaves the count unchanged and the table full
    a_reject_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_en && !placed |=> count_reg == CNT_BITS'(DEPTH) && $stable(count_reg))
        else $error("rejection with free cells");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import tkst_pkg::*;

    localparam int DEPTH     = 16;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int MAX_PRINT = 40;
    localparam logic [SCORE_W-1:0] TOP_SCORE = {SCORE_W{1'b1}};

    typedef struct packed {
        func_t              func;
        logic [SCORE_W-1:0] score;
        logic [IDX_W-1:0]   idx;
    } table_op_t;

    typedef struct packed {
        logic               placed;
        logic [CNT_W-1:0]   position;
        logic [SCORE_W-1:0] entry_score;
        logic               entry_valid;
        logic [CNT_W-1:0]   fill_count;
    } table_reply_t;

    logic               aclk          = 1'b0;
    logic               aresetn       = 1'b0;
    logic               s_valid       = 1'b0;
    logic               s_ready;
    logic               s_func        = 1'b0;
    logic [SCORE_W-1:0] s_new_score   = '0;
    logic [IDX_W-1:0]   s_read_index  = '0;
    logic               m_valid;
    logic               m_ready       = 1'b0;
    logic               m_placed;
    logic [CNT_W-1:0]   m_position;
    logic [SCORE_W-1:0] m_entry_score;
    logic               m_entry_valid;
    logic [CNT_W-1:0]   m_fill_count;

    // Shadow copy of the score table
    logic [SCORE_W-1:0] kept_scores [DEPTH];
    int                 kept_count;

    table_op_t    pending_ops [$];
    table_reply_t due_replies [$];
    int           error_count = 0;

    // Idle control per side
    int tx_wait    = 0;
    int rx_wait    = 0;
    int tx_beats   = 0;
    int rx_beats   = 0;
    bit tx_steady  = 1'b0;
    bit rx_steady  = 1'b0;

    top_k_sorted_insert_table #(
        .DEPTH(DEPTH)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_new_score   (s_new_score),
        .s_read_index  (s_read_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_placed      (m_placed),
        .m_position    (m_position),
        .m_entry_score (m_entry_score),
        .m_entry_valid (m_entry_valid),
        .m_fill_count  (m_fill_count)
    );

    always #5 aclk = ~aclk;

    task automatic flag_mismatch(input string msg);
        if (error_count < MAX_PRINT) begin
            $display("%0t ERROR: %s", $time, msg);
        end
        error_count++;
    endtask

    // Apply one operation to the shadow table and return the reply it causes
    function automatic table_reply_t apply_to_table(input table_op_t op);
        table_reply_t r;
        int           slot;
        int           last;
        r = '0;
        if (op.func == FUNC_INSERT) begin
            // first entry strictly below the new score; ties go after
            slot = kept_count;
            for (int i = kept_count - 1; i >= 0; i--) begin
                if (op.score > kept_scores[i]) slot = i;
            end
            if (slot >= DEPTH) begin
                r.position = CNT_W'(DEPTH);
            end else begin
                last = (kept_count < DEPTH) ? kept_count : DEPTH - 1;
                if (kept_count < DEPTH) kept_count++;
                for (int i = last; i > slot; i--) kept_scores[i] = kept_scores[i-1];
                kept_scores[slot] = op.score;
                r.placed   = 1'b1;
                r.position = CNT_W'(slot);
            end
        end else if (int'(op.idx) < kept_count) begin
            r.entry_score = kept_scores[op.idx[ADDR_W-1:0]];
            r.entry_valid = 1'b1;
        end
        r.fill_count = CNT_W'(kept_count);
        return r;
    endfunction

    task automatic add_insert(input logic [SCORE_W-1:0] score);
        table_op_t op;
        op       = '0;
        op.func  = FUNC_INSERT;
        op.score = score;
        op.idx   = IDX_W'($urandom);
        pending_ops.push_back(op);
    endtask

    task automatic add_read(input int idx);
        table_op_t op;
        op       = '0;
        op.func  = FUNC_READ;
        op.score = SCORE_W'($urandom);
        op.idx   = IDX_W'(idx);
        pending_ops.push_back(op);
    endtask

    // Driver: one beat per item, random gap after each
    always @(posedge aclk) begin
        table_op_t op;
        logic      next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                op.func  = func_t'(s_func);
                op.score = s_new_score;
                op.idx   = s_read_index;
                due_replies.push_back(apply_to_table(op));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (pending_ops.size() > 0) begin
                    op = pending_ops.pop_front();
                    s_func       <= op.func;
                    s_new_score  <= op.score;
                    s_read_index <= op.idx;
                    next_valid   = 1'b1;
                    if (tx_beats % 48 == 0) tx_steady = ($urandom_range(0, 3) == 0);
                    tx_beats++;
                    tx_wait = tx_steady ? 0 : $urandom_range(0, 5);
                end
            end
            s_valid <= next_valid;
        end
    end

    // Monitor: check each result beat against the oldest prediction
    always @(posedge aclk) begin
        table_reply_t exp;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_replies.size() == 0) begin
                    flag_mismatch("result beat with nothing expected");
                end else begin
                    exp = due_replies.pop_front();
                    if (m_placed !== exp.placed)
                        flag_mismatch($sformatf("placed %0b, expected %0b",
                                                m_placed, exp.placed));
                    if (m_position !== exp.position)
                        flag_mismatch($sformatf("position %0d, expected %0d",
                                                m_position, exp.position));
                    if (m_entry_score !== exp.entry_score)
                        flag_mismatch($sformatf("entry_score %0h, expected %0h",
                                                m_entry_score, exp.entry_score));
                    if (m_entry_valid !== exp.entry_valid)
                        flag_mismatch($sformatf("entry_valid %0b, expected %0b",
                                                m_entry_valid, exp.entry_valid));
                    if (m_fill_count !== exp.fill_count)
                        flag_mismatch($sformatf("fill_count %0d, expected %0d",
                                                m_fill_count, exp.fill_count));
                end
                if (rx_beats % 40 == 0) rx_steady = ($urandom_range(0, 3) == 0);
                rx_beats++;
                rx_wait = rx_steady ? 0 : $urandom_range(0, 5);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_ready <= (rx_wait == 0);
        end
    end

    // Stimulus and end of run
    initial begin
        int          kind;
        int          chunk_step;
        logic [31:0] base;
        logic [31:0] score;
        for (int i = 0; i < DEPTH; i++) kept_scores[i] = '0;
        kept_count = 0;

        // reads of an empty table, extremes, ties, filling up, rejection
        add_read(0);
        add_read(63);
        add_insert('0);
        add_insert(TOP_SCORE);
        add_insert(TOP_SCORE);
        add_insert(100);
        add_insert(100);
        add_insert(50);
        add_read(0);
        add_read(3);
        for (int i = 0; i < 10; i++) add_insert(10);
        add_insert('0);          // full, beats nothing
        add_insert(10);          // beats only the trailing zero
        add_insert(5);           // full, rejected
        add_insert(TOP_SCORE);   // lands after the equal top scores
        add_read(DEPTH - 1);
        add_read(DEPTH);
        add_read(63);

        // random part: a rising score floor keeps inserts landing in the table
        chunk_step = 32'h7FFF0000 / 80;
        for (int n = 0; n < 1275; n++) begin
            base = (n / 16) * chunk_step;
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                if ($urandom_range(0, 9) < 7) add_read($urandom_range(0, DEPTH - 1));
                else add_read($urandom_range(0, 63));
            end else if (kind < 40) begin
                // low scores that mostly get turned away
                add_insert(SCORE_W'($urandom_range(0, base)));
            end else if (kind < 42) begin
                add_insert(SCORE_W'($urandom));
            end else begin
                if ($urandom_range(0, 1) == 0) score = base + $urandom_range(0, 3);
                else score = base + $urandom_range(0, chunk_step);
                if (score > {1'b0, TOP_SCORE}) score = {1'b0, TOP_SCORE};
                add_insert(score[SCORE_W-1:0]);
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_ops.size() != 0 || s_valid || due_replies.size() != 0)
            @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (due_replies.size() != 0) flag_mismatch("expected results never arrived");

        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
